// File: rtl/core/scvp_pkg.sv
package scvp_pkg;

	localparam int SLOTS_DEF     = 4;
	localparam int FOUND_MAX_DEF = 32;
	localparam int CELLS         = 6;
	localparam int FIXED_COUNT   = 28;

	localparam logic [7:0]  START_BYTE  = 8'h7E;
	localparam logic [7:0]  HEADER_BYTE = 8'h10;
	localparam logic [15:0] ID_LOW      = 16'h0300;
	localparam logic [15:0] ID_HIGH     = 16'h030F;
	localparam logic [13:0] RECIP_5     = 14'd3277;

	typedef enum logic [1:0] {
		OP_POLL,
		OP_HEADER,
		OP_BYTE
	} op_t;

	typedef enum logic [1:0] {
		KIND_TX      = 2'd0,
		KIND_READING = 2'd1,
		KIND_NO_SLOT = 2'd2,
		KIND_NEW_ID  = 2'd3
	} kind_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  rx_byte;
		logic [31:0] now_ms;
	} cmd_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic        last;
		logic [3:0]  slot;
		logic [15:0] sensor_id;
		logic [3:0]  cell_count;
		logic [3:0]  cell_group;
		logic [9:0]  cell_first;
		logic [9:0]  cell_second;
		logic [12:0] pack_centivolts;
		logic [31:0] stamp_ms;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_POLL_A,
		S_POLL_B,
		S_HDR_RD,
		S_HDR_CMP,
		S_HDR_EMIT,
		S_DEC,
		S_FULL,
		S_DIV,
		S_WR0,
		S_WR1,
		S_SUM,
		S_RPT
	} state_t;

	function automatic logic [7:0] fixed_id(input logic [4:0] idx);
		logic [7:0] v;
		case (idx)
			5'd1:    v = 8'hA1;
			5'd2:    v = 8'h22;
			5'd3:    v = 8'h83;
			5'd4:    v = 8'hE4;
			5'd5:    v = 8'h45;
			5'd6:    v = 8'hC6;
			5'd7:    v = 8'h67;
			5'd8:    v = 8'h48;
			5'd9:    v = 8'hE9;
			5'd10:   v = 8'h6A;
			5'd11:   v = 8'hCB;
			5'd12:   v = 8'hAC;
			5'd13:   v = 8'h0D;
			5'd14:   v = 8'h8E;
			5'd15:   v = 8'h2F;
			5'd16:   v = 8'hD0;
			5'd17:   v = 8'h71;
			5'd18:   v = 8'hF2;
			5'd19:   v = 8'h53;
			5'd20:   v = 8'h34;
			5'd21:   v = 8'h95;
			5'd22:   v = 8'h16;
			5'd23:   v = 8'hB7;
			5'd24:   v = 8'h98;
			5'd25:   v = 8'h39;
			5'd26:   v = 8'hBA;
			5'd27:   v = 8'h1B;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/core/sport_cell_voltage_poller_top.sv
// A poll tick emits its start byte in S_POLL_A and then its id byte in S_POLL_B.
// A plain received byte is consumed in S_IDLE; a header searches the discovered ids through
// S_HDR_RD and S_HDR_CMP, and if its id is new stores it and reports it in S_HDR_EMIT.
// The last frame byte passes S_DEC, S_DIV, S_WR0 and S_WR1 (skipped when the group stores
// nothing) and six cell reads in S_SUM before its reading in S_RPT; items are handled one at a time.
// Reset is asynchronous and active low; it clears all control state and frees every slot.
module sport_cell_voltage_poller_top #(
	parameter int SLOTS     = scvp_pkg::SLOTS_DEF,
	parameter int FOUND_MAX = scvp_pkg::FOUND_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  rx_byte,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic        last,
	output logic [3:0]  slot,
	output logic [15:0] sensor_id,
	output logic [3:0]  cell_count,
	output logic [3:0]  cell_group,
	output logic [9:0]  cell_first,
	output logic [9:0]  cell_second,
	output logic [12:0] pack_centivolts,
	output logic [31:0] stamp_ms
);

	logic           cmd_valid;
	logic           cmd_pop;
	scvp_pkg::cmd_t cmd;
	scvp_pkg::res_t res;

	scvp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.rx_byte   (rx_byte),
		.now_ms    (now_ms),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	scvp_back #(
		.SLOTS     (SLOTS),
		.FOUND_MAX (FOUND_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign kind            = res.kind;
	assign data_byte       = res.data_byte;
	assign last            = res.last;
	assign slot            = res.slot;
	assign sensor_id       = res.sensor_id;
	assign cell_count      = res.cell_count;
	assign cell_group      = res.cell_group;
	assign cell_first      = res.cell_first;
	assign cell_second     = res.cell_second;
	assign pack_centivolts = res.pack_centivolts;
	assign stamp_ms        = res.stamp_ms;

endmodule

// File: rtl/core/scvp_front.sv
module scvp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [7:0]        rx_byte,
	input  logic [31:0]       now_ms,
	output logic              cmd_valid,
	input  logic              cmd_pop,
	output scvp_pkg::cmd_t    cmd
);

	scvp_pkg::cmd_t fifo_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	scvp_pkg::cmd_t cls;
	logic           push;
	logic           pop;

	always_comb begin
		cls.rx_byte = rx_byte;
		cls.now_ms  = now_ms;
		if (!req_type) begin
			cls.op = scvp_pkg::OP_POLL;
		end else if (rx_byte == scvp_pkg::HEADER_BYTE) begin
			cls.op = scvp_pkg::OP_HEADER;
		end else begin
			cls.op = scvp_pkg::OP_BYTE;
		end
	end

	assign in_ready  = (count_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/core/scvp_back.sv
module scvp_back #(
	parameter int SLOTS     = scvp_pkg::SLOTS_DEF,
	parameter int FOUND_MAX = scvp_pkg::FOUND_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_pop,
	input  scvp_pkg::cmd_t    cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output scvp_pkg::res_t    res
);

	localparam int SL_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int FI_W   = (FOUND_MAX > 1) ? $clog2(FOUND_MAX) : 1;
	localparam int FC_W   = $clog2(FOUND_MAX + 1);
	localparam int NCELL  = SLOTS * scvp_pkg::CELLS;
	localparam int CA_W   = (NCELL > 1) ? $clog2(NCELL) : 1;

	scvp_pkg::state_t state_q, state_d;

	logic             parity_q;
	logic [4:0]       scan_q;
	logic [FI_W-1:0]  found_idx_q;
	logic [FC_W-1:0]  found_cnt_q;
	logic [7:0]       prev_q;
	logic [3:0]       phase_q;
	logic [7:0]       fb_q [7];
	logic [15:0]      slot_ids_q [SLOTS];
	logic             use_found_q;
	logic [7:0]       fixed_q;
	logic [FC_W-1:0]  hi_q;
	logic [SL_W-1:0]  slot_q;
	logic [CA_W-1:0]  base_q;
	logic [9:0]       first_q;
	logic [9:0]       second_q;
	logic [2:0]       k_q;
	logic [12:0]      acc_q;
	logic [31:0]      stamp_q;
	logic             out_valid_q;
	scvp_pkg::res_t   out_q;

	logic [7:0]       found_mem [FOUND_MAX];
	logic [7:0]       f_rdata_q;
	logic             f_re, f_we;
	logic [FI_W-1:0]  f_raddr, f_waddr;

	logic [9:0]       cell_mem [NCELL];
	logic [NCELL-1:0] cvalid_q;
	logic [9:0]       c_rdata_q;
	logic             c_rvalid_q;
	logic             c_re, c_we;
	logic [CA_W-1:0]  c_raddr, c_waddr;
	logic [9:0]       c_wdata;

	logic             can_emit, emit;
	scvp_pkg::res_t   res_d;

	logic [15:0]      frame_id;
	logic [3:0]       group;
	logic             group_ok;
	logic             slot_hit;
	logic [SL_W-1:0]  slot_sel;
	logic [FC_W:0]    fidx_inc;
	logic [25:0]      prod_first, prod_second;

	assign frame_id    = {fb_q[1], fb_q[0]};
	assign group       = fb_q[2][3:0];
	assign group_ok    = (group == 4'd0) || (group == 4'd2) || (group == 4'd4);
	assign fidx_inc    = {{(FC_W + 1 - FI_W){1'b0}}, found_idx_q} + 1'b1;
	assign prod_first  = {fb_q[4][3:0], fb_q[3]} * scvp_pkg::RECIP_5;
	assign prod_second = {fb_q[5], fb_q[4][7:4]} * scvp_pkg::RECIP_5;
	assign can_emit    = !out_valid_q || out_ready;

	always_comb begin
		slot_hit = 1'b0;
		slot_sel = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (slot_ids_q[i] == frame_id || slot_ids_q[i] == 16'd0) begin
				slot_hit = 1'b1;
				slot_sel = SL_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scvp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		emit    = 1'b0;
		res_d   = '0;
		f_re    = 1'b0;
		f_we    = 1'b0;
		f_raddr = found_idx_q;
		f_waddr = found_cnt_q[FI_W-1:0];
		c_re    = 1'b0;
		c_we    = 1'b0;
		c_raddr = base_q + CA_W'(k_q);
		c_waddr = base_q + CA_W'(group);
		c_wdata = first_q;
		unique case (state_q)
			scvp_pkg::S_IDLE: begin
				f_re = 1'b1;
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.op == scvp_pkg::OP_POLL) begin
						state_d = scvp_pkg::S_POLL_A;
					end else if (phase_q == 4'd0) begin
						if (cmd.op == scvp_pkg::OP_HEADER && prev_q != 8'd0 &&
						    found_cnt_q < FC_W'(FOUND_MAX)) begin
							state_d = scvp_pkg::S_HDR_RD;
						end
					end else if (phase_q == 4'd7) begin
						state_d = scvp_pkg::S_DEC;
					end
				end
			end
			scvp_pkg::S_POLL_A: begin
				res_d.kind      = scvp_pkg::KIND_TX;
				res_d.data_byte = scvp_pkg::START_BYTE;
				if (can_emit) begin
					emit    = 1'b1;
					state_d = scvp_pkg::S_POLL_B;
				end
			end
			scvp_pkg::S_POLL_B: begin
				res_d.kind      = scvp_pkg::KIND_TX;
				res_d.data_byte = use_found_q ? f_rdata_q : fixed_q;
				res_d.last      = 1'b1;
				if (can_emit) begin
					emit    = 1'b1;
					state_d = scvp_pkg::S_IDLE;
				end
			end
			scvp_pkg::S_HDR_RD: begin
				if (hi_q == found_cnt_q) begin
					f_we    = 1'b1;
					state_d = scvp_pkg::S_HDR_EMIT;
				end else begin
					f_re    = 1'b1;
					f_raddr = hi_q[FI_W-1:0];
					state_d = scvp_pkg::S_HDR_CMP;
				end
			end
			scvp_pkg::S_HDR_CMP: begin
				state_d = (f_rdata_q == prev_q) ? scvp_pkg::S_IDLE : scvp_pkg::S_HDR_RD;
			end
			scvp_pkg::S_HDR_EMIT: begin
				res_d.kind      = scvp_pkg::KIND_NEW_ID;
				res_d.data_byte = prev_q;
				res_d.last      = 1'b1;
				if (can_emit) begin
					emit    = 1'b1;
					state_d = scvp_pkg::S_IDLE;
				end
			end
			scvp_pkg::S_DEC: begin
				if (frame_id < scvp_pkg::ID_LOW || frame_id > scvp_pkg::ID_HIGH) begin
					state_d = scvp_pkg::S_IDLE;
				end else if (slot_hit) begin
					state_d = scvp_pkg::S_DIV;
				end else begin
					state_d = scvp_pkg::S_FULL;
				end
			end
			scvp_pkg::S_FULL: begin
				res_d.kind      = scvp_pkg::KIND_NO_SLOT;
				res_d.sensor_id = frame_id;
				res_d.last      = 1'b1;
				if (can_emit) begin
					emit    = 1'b1;
					state_d = scvp_pkg::S_IDLE;
				end
			end
			scvp_pkg::S_DIV: begin
				state_d = group_ok ? scvp_pkg::S_WR0 : scvp_pkg::S_SUM;
			end
			scvp_pkg::S_WR0: begin
				c_we    = 1'b1;
				state_d = scvp_pkg::S_WR1;
			end
			scvp_pkg::S_WR1: begin
				c_we    = 1'b1;
				c_waddr = base_q + CA_W'(group) + 1'b1;
				c_wdata = second_q;
				state_d = scvp_pkg::S_SUM;
			end
			scvp_pkg::S_SUM: begin
				c_re = (k_q < 3'd6);
				if (k_q == 3'd6) begin
					state_d = scvp_pkg::S_RPT;
				end
			end
			scvp_pkg::S_RPT: begin
				res_d.kind            = scvp_pkg::KIND_READING;
				res_d.last            = 1'b1;
				res_d.slot            = 4'(slot_q);
				res_d.sensor_id       = frame_id;
				res_d.cell_count      = fb_q[2][7:4];
				res_d.cell_group      = group;
				res_d.cell_first      = first_q;
				res_d.cell_second     = second_q;
				res_d.pack_centivolts = acc_q;
				res_d.stamp_ms        = stamp_q;
				if (can_emit) begin
					emit    = 1'b1;
					state_d = scvp_pkg::S_IDLE;
				end
			end
			default: state_d = scvp_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (f_we) begin
			found_mem[f_waddr] <= prev_q;
		end
		if (f_re) begin
			f_rdata_q <= found_mem[f_raddr];
		end
		if (c_we) begin
			cell_mem[c_waddr] <= c_wdata;
		end
		if (c_re) begin
			c_rdata_q <= cell_mem[c_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q    <= 1'b0;
			scan_q      <= '0;
			found_idx_q <= '0;
			found_cnt_q <= '0;
			prev_q      <= '0;
			phase_q     <= '0;
			cvalid_q    <= '0;
			c_rvalid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_ids_q[i] <= '0;
			end
		end else begin
			if (c_we) begin
				cvalid_q[c_waddr] <= 1'b1;
			end
			if (c_re) begin
				c_rvalid_q <= cvalid_q[c_raddr];
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == scvp_pkg::S_IDLE && cmd_valid) begin
				if (cmd.op == scvp_pkg::OP_POLL) begin
					parity_q <= ~parity_q;
					phase_q  <= '0;
					if (found_cnt_q != '0 && parity_q) begin
						found_idx_q <= (fidx_inc >= {1'b0, found_cnt_q}) ? '0 :
						               fidx_inc[FI_W-1:0];
					end else begin
						scan_q <= (scan_q == 5'(scvp_pkg::FIXED_COUNT - 1)) ? '0 :
						          scan_q + 5'd1;
					end
				end else if (phase_q == 4'd0) begin
					if (cmd.op == scvp_pkg::OP_HEADER) begin
						phase_q <= 4'd1;
					end else begin
						prev_q <= cmd.rx_byte;
					end
				end else if (phase_q == 4'd7) begin
					phase_q <= '0;
				end else begin
					phase_q <= phase_q + 4'd1;
				end
			end
			if (state_q == scvp_pkg::S_HDR_RD && hi_q == found_cnt_q) begin
				found_cnt_q <= found_cnt_q + 1'b1;
			end
			if (state_q == scvp_pkg::S_DEC && slot_hit &&
			    frame_id >= scvp_pkg::ID_LOW && frame_id <= scvp_pkg::ID_HIGH) begin
				slot_ids_q[slot_sel] <= frame_id;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == scvp_pkg::S_IDLE && cmd_valid) begin
			use_found_q <= (found_cnt_q != '0) && parity_q;
			fixed_q     <= scvp_pkg::fixed_id(scan_q);
			hi_q        <= '0;
			stamp_q     <= cmd.now_ms;
			if (cmd.op != scvp_pkg::OP_POLL && phase_q != 4'd0) begin
				fb_q[phase_q[2:0] - 3'd1] <= cmd.rx_byte;
			end
		end
		if (state_q == scvp_pkg::S_HDR_CMP) begin
			hi_q <= hi_q + 1'b1;
		end
		if (state_q == scvp_pkg::S_DEC) begin
			slot_q <= slot_sel;
		end
		if (state_q == scvp_pkg::S_DIV) begin
			first_q  <= prod_first[23:14];
			second_q <= prod_second[23:14];
			base_q   <= CA_W'(slot_q * scvp_pkg::CELLS);
			acc_q    <= '0;
			k_q      <= '0;
		end
		if (state_q == scvp_pkg::S_SUM) begin
			k_q <= k_q + 3'd1;
			if (k_q != 3'd0) begin
				acc_q <= acc_q + (c_rvalid_q ? {3'd0, c_rdata_q} : 13'd0);
			end
		end
		if (emit) begin
			out_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = out_q;

endmodule

// File: rtl/core/scvp_checker.sv
module scvp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [7:0]  data_byte,
	input logic        last,
	input logic [9:0]  cell_first,
	input logic [12:0] pack_centivolts
);

	property p_out_hold;
		@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte);
	endproperty
	a_out_hold: assert property (p_out_hold) else $error("Output item changed while stalled.");

	property p_start_first;
		@(posedge clk) disable iff (!arst_n)
		out_valid && kind == scvp_pkg::KIND_TX && !last |-> data_byte == scvp_pkg::START_BYTE;
	endproperty
	a_start_first: assert property (p_start_first)
		else $error("Non-final transmit item is not start byte.");

	property p_single_last;
		@(posedge clk) disable iff (!arst_n)
		out_valid && kind != scvp_pkg::KIND_TX |-> last;
	endproperty
	a_single_last: assert property (p_single_last) else $error("Single result not marked last.");

	property p_range;
		@(posedge clk) disable iff (!arst_n)
		out_valid && kind == scvp_pkg::KIND_READING |->
			cell_first <= 10'd819 && pack_centivolts <= 13'd4914;
	endproperty
	a_range: assert property (p_range) else $error("Reading out of range.");

endmodule

bind sport_cell_voltage_poller_top scvp_checker u_scvp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.kind            (kind),
	.data_byte       (data_byte),
	.last            (last),
	.cell_first      (cell_first),
	.pack_centivolts (pack_centivolts)
);

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;

	typedef struct {
		bit          is_byte;
		logic [7:0]  rx;
		logic [31:0] now;
	} bus_item_t;

	localparam logic [7:0] POLL_IDS [0:27] = '{
		8'h00, 8'hA1, 8'h22, 8'h83, 8'hE4, 8'h45, 8'hC6, 8'h67, 8'h48, 8'hE9,
		8'h6A, 8'hCB, 8'hAC, 8'h0D, 8'h8E, 8'h2F, 8'hD0, 8'h71, 8'hF2, 8'h53,
		8'h34, 8'h95, 8'h16, 8'hB7, 8'h98, 8'h39, 8'hBA, 8'h1B};
	localparam int NSLOT    = 4;
	localparam int LIST_MAX = 32;
	localparam int WATCHDOG = 4000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        req_type;
	logic [7:0]  rx_byte;
	logic [31:0] now_ms;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic        last;
	logic [3:0]  slot;
	logic [15:0] sensor_id;
	logic [3:0]  cell_count;
	logic [3:0]  cell_group;
	logic [9:0]  cell_first;
	logic [9:0]  cell_second;
	logic [12:0] pack_centivolts;
	logic [31:0] stamp_ms;

	bus_item_t      pending_items[$];
	scvp_pkg::res_t awaited_results[$];
	int             errors;
	int             sent_count;
	int             idle_count;

	bit          poll_odd;
	int          scan_pos;
	int          found_pos;
	int          found_total;
	logic [7:0]  found_list [32];
	logic [7:0]  last_rx;
	int          frame_pos;
	logic [55:0] frame_buf;
	logic [15:0] slot_tag [NSLOT];
	logic [9:0]  cell_mv [NSLOT * 6];

	sport_cell_voltage_poller_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .rx_byte(rx_byte), .now_ms(now_ms),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .data_byte(data_byte), .last(last), .slot(slot),
		.sensor_id(sensor_id), .cell_count(cell_count), .cell_group(cell_group),
		.cell_first(cell_first), .cell_second(cell_second),
		.pack_centivolts(pack_centivolts), .stamp_ms(stamp_ms)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic scvp_pkg::res_t blank_result(scvp_pkg::kind_t k, logic [7:0] d);
		scvp_pkg::res_t r;
		r = '0;
		r.kind = k;
		r.data_byte = d;
		r.last = 1'b1;
		return r;
	endfunction

	task automatic decode_reading(input logic [31:0] now);
		logic [15:0]    id;
		logic [31:0]    payload;
		int             s;
		int             base;
		int             sum;
		scvp_pkg::res_t r;
		id = frame_buf[15:0];
		payload = frame_buf[47:16];
		s = NSLOT;
		if (id < scvp_pkg::ID_LOW || id > scvp_pkg::ID_HIGH)
			return;
		for (int i = 0; i < NSLOT; i++) begin
			if (slot_tag[i] == id) begin
				s = i;
				break;
			end
			if (slot_tag[i] == 16'h0) begin
				slot_tag[i] = id;
				s = i;
				break;
			end
		end
		if (s == NSLOT) begin
			r = blank_result(scvp_pkg::KIND_NO_SLOT, 8'h00);
			r.sensor_id = id;
			awaited_results.push_back(r);
			return;
		end
		r = blank_result(scvp_pkg::KIND_READING, 8'h00);
		r.slot = 4'(s);
		r.sensor_id = id;
		r.cell_group = payload[3:0];
		r.cell_count = payload[7:4];
		r.cell_first = 10'(payload[19:8] / 5);
		r.cell_second = 10'(payload[31:20] / 5);
		base = s * 6;
		if (payload[3:0] == 4'd0 || payload[3:0] == 4'd2 || payload[3:0] == 4'd4) begin
			cell_mv[base + payload[3:0]] = r.cell_first;
			cell_mv[base + payload[3:0] + 1] = r.cell_second;
		end
		sum = 0;
		for (int i = 0; i < 6; i++)
			sum += cell_mv[base + i];
		r.pack_centivolts = 13'(sum);
		r.stamp_ms = now;
		awaited_results.push_back(r);
	endtask

	task automatic predict_item(input bus_item_t it);
		logic [7:0]     id;
		scvp_pkg::res_t r;
		bit             known;
		if (!it.is_byte) begin
			if (found_total != 0 && poll_odd) begin
				id = found_list[found_pos];
				found_pos = (found_pos + 1 >= found_total) ? 0 : found_pos + 1;
			end else begin
				id = POLL_IDS[scan_pos];
				scan_pos = (scan_pos + 1) % 28;
			end
			poll_odd = !poll_odd;
			frame_pos = 0;
			frame_buf = '0;
			r = blank_result(scvp_pkg::KIND_TX, scvp_pkg::START_BYTE);
			r.last = 1'b0;
			awaited_results.push_back(r);
			awaited_results.push_back(blank_result(scvp_pkg::KIND_TX, id));
		end else if (frame_pos == 0) begin
			if (it.rx == scvp_pkg::HEADER_BYTE) begin
				frame_pos = 1;
				frame_buf = '0;
				known = 0;
				for (int i = 0; i < found_total; i++)
					if (found_list[i] == last_rx)
						known = 1;
				if (last_rx != 8'h00 && found_total < LIST_MAX && !known) begin
					found_list[found_total] = last_rx;
					found_total++;
					awaited_results.push_back(blank_result(scvp_pkg::KIND_NEW_ID, last_rx));
				end
			end else begin
				last_rx = it.rx;
			end
		end else begin
			frame_buf[(frame_pos - 1) * 8 +: 8] = it.rx;
			if (frame_pos < 7) begin
				frame_pos++;
			end else begin
				frame_pos = 0;
				decode_reading(it.now);
			end
		end
	endtask

	task automatic queue_item(input bit is_byte, input logic [7:0] b);
		bus_item_t it;
		it.is_byte = is_byte;
		it.rx = b;
		it.now = $urandom;
		pending_items.push_back(it);
	endtask

	task automatic queue_frame(input logic [7:0] tag, input logic [15:0] id,
			input logic [31:0] payload, input int nbytes);
		logic [55:0] body;
		body = {8'($urandom_range(0, 255)), payload, id};
		queue_item(1, tag);
		queue_item(1, scvp_pkg::HEADER_BYTE);
		for (int i = 0; i < nbytes; i++)
			queue_item(1, body[i * 8 +: 8]);
	endtask

	function automatic int phase_of(int n);
		return (n / 120) % 4;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bus_item_t it;
		bit        go;
		int        ph;
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= 1'b0;
			rx_byte <= 8'h00;
			now_ms <= 32'h0;
			out_ready <= 1'b0;
			sent_count <= 0;
		end else begin
			if (in_valid && in_ready) begin
				it.is_byte = req_type;
				it.rx = rx_byte;
				it.now = now_ms;
				predict_item(it);
				sent_count <= sent_count + 1;
			end
			ph = phase_of(sent_count);
			if (!in_valid || in_ready) begin
				go = pending_items.size() != 0;
				if ((ph == 1 && $urandom_range(0, 99) < 53) ||
						(ph == 3 && $urandom_range(0, 99) < 10))
					go = 0;
				if (go) begin
					it = pending_items.pop_front();
					in_valid <= 1'b1;
					req_type <= it.is_byte;
					rx_byte <= it.rx;
					now_ms <= it.now;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= !((ph == 2 && $urandom_range(0, 99) < 53) ||
					(ph == 3 && $urandom_range(0, 99) < 10));
		end
	end

	always @(posedge clk) begin
		scvp_pkg::res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result kind %0d data %h", $time, kind, data_byte);
				errors++;
			end else begin
				want = awaited_results.pop_front();
				if ({kind, data_byte, last, slot, sensor_id, cell_count, cell_group,
						cell_first, cell_second, pack_centivolts, stamp_ms} !== want) begin
					$display("%0t: expected kind %0d data %h last %0d slot %0d id %h",
						$time, want.kind, want.data_byte, want.last, want.slot,
						want.sensor_id);
					$display("    cells %0d grp %0d %0d/%0d pack %0d stamp %h",
						want.cell_count, want.cell_group, want.cell_first,
						want.cell_second, want.pack_centivolts, want.stamp_ms);
					$display("  actual kind %0d data %h last %0d slot %0d id %h",
						kind, data_byte, last, slot, sensor_id);
					$display("    cells %0d grp %0d %0d/%0d pack %0d stamp %h",
						cell_count, cell_group, cell_first, cell_second,
						pack_centivolts, stamp_ms);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_count <= 0;
		end else begin
			idle_count <= idle_count + 1;
			if (idle_count >= WATCHDOG) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int r;
		int n;
		logic [31:0] payload;
		errors = 0;
		idle_count = 0;
		poll_odd = 0;
		scan_pos = 0;
		found_pos = 0;
		found_total = 0;
		last_rx = 8'h00;
		frame_pos = 0;
		frame_buf = '0;
		foreach (slot_tag[i])
			slot_tag[i] = 16'h0;
		foreach (cell_mv[i])
			cell_mv[i] = 10'h0;

		arst_n = 1'b0;
		queue_item(0, 8'hFF);
		queue_frame(8'h00, 16'h0300, 32'hFFFFF060, 7);
		queue_frame(8'hFF, 16'h0300, 32'h00000062, 7);
		queue_item(0, 8'h00);
		queue_frame(8'hFF, 16'h030F, 32'hFFF00044, 7);
		queue_item(0, 8'h00);
		queue_frame(8'h5A, 16'h0301, 32'h12345607, 4);
		queue_item(0, 8'h00);
		queue_frame(8'h01, 16'h0302, 32'hABCDEF00, 7);
		queue_frame(8'h02, 16'h0303, 32'h00000000, 7);
		queue_frame(8'h03, 16'h02FF, 32'h00000000, 7);
		queue_frame(8'h04, 16'hFFFF, 32'hFFFFFFFF, 7);
		queue_item(0, 8'h00);
		queue_item(0, 8'h00);

		while (pending_items.size() < 950) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				queue_item(0, 8'($urandom));
			end else if (r < 25) begin
				queue_item(1, 8'($urandom));
			end else if (r < 32) begin
				queue_frame(8'($urandom), 16'(16'h0300 + $urandom_range(0, 15)), $urandom,
					$urandom_range(0, 6));
				queue_item(0, 8'h00);
			end else begin
				payload = $urandom;
				if ($urandom_range(0, 1))
					payload[3:0] = 4'(2 * $urandom_range(0, 2));
				n = $urandom_range(0, 99);
				queue_frame((n < 30) ? 8'($urandom_range(0, 7)) : 8'($urandom),
					(n < 85) ? 16'(16'h0300 + $urandom_range(0, 15)) : 16'($urandom),
					payload, 7);
			end
		end

		repeat (10) @(posedge clk);
		arst_n = 1'b1;

		@(negedge clk);
		while (pending_items.size() != 0 || in_valid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && awaited_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/scvp_pkg.sv
rtl/core/scvp_front.sv
rtl/core/scvp_back.sv
rtl/core/sport_cell_voltage_poller_top.sv
rtl/core/scvp_checker.sv
bench/tb.sv
